FILE: rtl/rof_pkg.sv
// shared types and constants for the rectangle occlusion finder
package rof_pkg;

	localparam int MAX_RECTS_DEF = 32;
	localparam int RESULT_CAP    = 32;
	localparam int IDX_W         = 5;
	localparam int COVER_W       = 15;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [14:0]        w;
		logic [14:0]        h;
	} rect_t;

	typedef struct packed {
		logic               hit;
		logic [COVER_W-1:0] x0;
		logic [COVER_W-1:0] y0;
		logic [COVER_W-1:0] x1;
		logic [COVER_W-1:0] y1;
	} ovl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage

FILE: rtl/rectangle_occlusion_finder.sv
// rectangle occlusion finder top level: control, rotating cell chain, output register
//
// channel  | valid     | ready     | beat
// ---------+-----------+-----------+-------------------------------------------
// input    | in_valid  | in_ready  | start_list, rect_x, rect_y, rect_w, rect_h
// output   | out_valid | out_ready | hit, older_index, cover_*, last, overflow
//
// when the store holds rectangles, the stored rectangles rotate once around the cell
// chain past the single compare unit. with an empty store or start_list set an item
// goes from idle straight to the flush state without a scan.
// reset clears the rectangle count and control; cell contents are not cleared.
// a stalled output holds the chain when a second overlap is found.
module rectangle_occlusion_finder
	import rof_pkg::*;
#(
	parameter int MAX_RECTS = MAX_RECTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               start_list,
	input  logic signed [15:0] rect_x,
	input  logic signed [15:0] rect_y,
	input  logic [14:0]        rect_w,
	input  logic [14:0]        rect_h,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic [IDX_W-1:0]   older_index,
	output logic [COVER_W-1:0] cover_x0,
	output logic [COVER_W-1:0] cover_y0,
	output logic [COVER_W-1:0] cover_x1,
	output logic [COVER_W-1:0] cover_y1,
	output logic               last,
	output logic               overflow
);

	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int HW = $clog2(RESULT_CAP + 1);

	state_t state_q, state_d;

	logic [CW-1:0] count_q, eff_q, step_q;
	logic [HW-1:0] hits_q;
	logic          ovf_q, pend_v_q, out_valid_q;
	rect_t         query_q;
	ovl_t          pend_q;
	logic [CW-1:0] pend_idx_q;

	logic hit_q, last_q, overflow_q;
	logic [IDX_W-1:0]   idx_q;
	logic [COVER_W-1:0] x0_q, y0_q, x1_q, y1_q;

	logic shift_en, push, push_pend, pend_load, commit, push_ok, found, accept;
	logic [CW-1:0] eff_in;
	logic [CW+IDX_W-1:0] idx_ext;

	rect_t cell_data [MAX_RECTS];
	rect_t new_rect;
	ovl_t  ovl;

	assign new_rect.x = rect_x;
	assign new_rect.y = rect_y;
	assign new_rect.w = rect_w;
	assign new_rect.h = rect_h;

	// chain rotates toward cell zero, the head feeds the compare unit
	for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
		localparam int NXT = (i + 1) % MAX_RECTS;
		rof_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.load_en  (commit && !ovf_q && (eff_q == CW'(i))),
			.shift_in (cell_data[NXT]),
			.load_in  (query_q),
			.data     (cell_data[i])
		);
	end

	rof_cmp u_cmp (
		.old_rect (cell_data[0]),
		.new_rect (query_q),
		.ovl      (ovl)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign eff_in   = start_list ? '0 : count_q;
	assign push_ok  = !out_valid_q || out_ready;
	assign found    = (state_q == ST_SCAN) && ovl.hit && (step_q < eff_q)
	                  && (hits_q < HW'(RESULT_CAP));

	always_comb begin
		state_d   = state_q;
		shift_en  = 1'b0;
		push      = 1'b0;
		push_pend = 1'b0;
		pend_load = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (eff_in == '0) ? ST_FLUSH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				// a second overlap needs the output register free
				if (!(found && pend_v_q && !push_ok)) begin
					shift_en = 1'b1;
					if (found) begin
						pend_load = 1'b1;
						if (pend_v_q) begin
							push      = 1'b1;
							push_pend = 1'b1;
						end
					end
					if (step_q == CW'(MAX_RECTS - 1)) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (push_ok) begin
					push      = 1'b1;
					push_pend = pend_v_q;
					commit    = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			step_q      <= '0;
			hits_q      <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				step_q <= '0;
				hits_q <= '0;
			end else if (shift_en) begin
				step_q <= step_q + CW'(1);
			end
			if (pend_load) begin
				hits_q <= hits_q + HW'(1);
			end
			if (commit) begin
				pend_v_q <= 1'b0;
				count_q  <= ovf_q ? eff_q : eff_q + CW'(1);
			end else if (pend_load) begin
				pend_v_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign idx_ext = {{IDX_W{1'b0}}, pend_idx_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= new_rect;
			eff_q   <= eff_in;
			ovf_q   <= (eff_in >= CW'(MAX_RECTS));
		end
		if (pend_load) begin
			pend_q     <= ovl;
			pend_idx_q <= step_q;
		end
		if (push) begin
			hit_q      <= push_pend;
			idx_q      <= push_pend ? idx_ext[IDX_W-1:0] : '0;
			x0_q       <= push_pend ? pend_q.x0 : '0;
			y0_q       <= push_pend ? pend_q.y0 : '0;
			x1_q       <= push_pend ? pend_q.x1 : '0;
			y1_q       <= push_pend ? pend_q.y1 : '0;
			last_q     <= (state_q == ST_FLUSH);
			overflow_q <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign hit         = hit_q;
	assign older_index = idx_q;
	assign cover_x0    = x0_q;
	assign cover_y0    = y0_q;
	assign cover_x1    = x1_q;
	assign cover_y1    = y1_q;
	assign last        = last_q;
	assign overflow    = overflow_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RECTS))
		else $error("rectangle count beyond store depth");

	a_hits_cap: assert property (@(posedge clk) disable iff (!arst_n)
		hits_q <= HW'(RESULT_CAP))
		else $error("overlap count beyond result cap");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("pending overlap left over after an item");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (step_q < CW'(MAX_RECTS)))
		else $error("scan step beyond chain length");

	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && push_ok) |=> (state_q == ST_IDLE && out_valid_q && last_q))
		else $error("final beat not delivered at end of item");
`endif

endmodule

FILE: rtl/rof_cell.sv
// one storage cell of the rotating rectangle chain
module rof_cell
	import rof_pkg::*;
(
	input  logic  clk,
	input  logic  shift_en,
	input  logic  load_en,
	input  rect_t shift_in,
	input  rect_t load_in,
	output rect_t data
);

	rect_t data_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= shift_in;
		end else if (load_en) begin
			data_q <= load_in;
		end
	end

	assign data = data_q;

endmodule

FILE: rtl/rof_cmp.sv
// inclusive overlap test of the head cell against the new rectangle
module rof_cmp
	import rof_pkg::*;
(
	input  rect_t old_rect,
	input  rect_t new_rect,
	output ovl_t  ovl
);

	logic signed [16:0] ox, oy, ow, oh, ox1, oy1;
	logic signed [16:0] nx, ny, nx1, ny1;
	logic signed [16:0] dx0, dy0, dx1, dy1;
	logic               miss;

	always_comb begin
		ox  = {old_rect.x[15], old_rect.x};
		oy  = {old_rect.y[15], old_rect.y};
		ow  = $signed({2'b00, old_rect.w});
		oh  = $signed({2'b00, old_rect.h});
		ox1 = ox + ow;
		oy1 = oy + oh;
		nx  = {new_rect.x[15], new_rect.x};
		ny  = {new_rect.y[15], new_rect.y};
		nx1 = nx + $signed({2'b00, new_rect.w});
		ny1 = ny + $signed({2'b00, new_rect.h});
		miss = (ox1 < nx) || (ox > nx1) || (oy1 < ny) || (oy > ny1);
		// only low bits matter: real values lie in 0..32767 when overlapping
		dx0 = nx - ox;
		dy0 = ny - oy;
		dx1 = nx1 - ox;
		dy1 = ny1 - oy;
		ovl.hit = !miss;
		ovl.x0  = (nx > ox) ? dx0[COVER_W-1:0] : '0;
		ovl.y0  = (ny > oy) ? dy0[COVER_W-1:0] : '0;
		ovl.x1  = (nx1 < ox1) ? dx1[COVER_W-1:0] : old_rect.w;
		ovl.y1  = (ny1 < oy1) ? dy1[COVER_W-1:0] : old_rect.h;
	end

endmodule

FILE: tb/tb_rectangle_occlusion_finder.sv
// testbench for the rectangle occlusion finder: directed and random rectangle lists
`timescale 1ns / 100ps

module tb_rectangle_occlusion_finder;
	import rof_pkg::*;

	localparam int NUM_RECTS      = MAX_RECTS_DEF;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = NUM_RECTS + 10;
	localparam int RANDOM_END     = 160;
	localparam int FINAL_END      = 210;

	typedef struct {
		logic               hit;
		logic [IDX_W-1:0]   idx;
		logic [COVER_W-1:0] x0;
		logic [COVER_W-1:0] y0;
		logic [COVER_W-1:0] x1;
		logic [COVER_W-1:0] y1;
		logic               last;
		logic               ovf;
	} cover_beat_t;

	logic               clk;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	logic               start_list  = 1'b0;
	logic signed [15:0] rect_x      = '0;
	logic signed [15:0] rect_y      = '0;
	logic [14:0]        rect_w      = '0;
	logic [14:0]        rect_h      = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	logic               hit;
	logic [IDX_W-1:0]   older_index;
	logic [COVER_W-1:0] cover_x0;
	logic [COVER_W-1:0] cover_y0;
	logic [COVER_W-1:0] cover_x1;
	logic [COVER_W-1:0] cover_y1;
	logic               last;
	logic               overflow;

	cover_beat_t expected_covers[$];
	int          kept_left[NUM_RECTS];
	int          kept_top[NUM_RECTS];
	int          kept_right[NUM_RECTS];
	int          kept_bottom[NUM_RECTS];
	int          kept_count   = 0;
	int          errors       = 0;
	int          items_sent   = 0;
	int          quiet_cycles = 0;
	int          stall_left   = 0;
	bit          idle_en      = 1'b1;

	rectangle_occlusion_finder #(
		.MAX_RECTS(NUM_RECTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_list(start_list),
		.rect_x(rect_x),
		.rect_y(rect_y),
		.rect_w(rect_w),
		.rect_h(rect_h),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit),
		.older_index(older_index),
		.cover_x0(cover_x0),
		.cover_y0(cover_y0),
		.cover_x1(cover_x1),
		.cover_y1(cover_y1),
		.last(last),
		.overflow(overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// expected overlap beats for one accepted rectangle, then keep it if there is room
	function automatic void predict_covers(input logic s, input logic [15:0] x,
			input logic [15:0] y, input logic [14:0] w, input logic [14:0] h);
		cover_beat_t batch[$];
		cover_beat_t beat;
		int          nl, nt, nr, nb;
		logic        full;
		if (s)
			kept_count = 0;
		nl   = int'($signed(x));
		nt   = int'($signed(y));
		nr   = nl + int'(w);
		nb   = nt + int'(h);
		full = (kept_count >= NUM_RECTS);
		for (int i = 0; i < kept_count && batch.size() < RESULT_CAP; i++) begin
			if (kept_right[i] < nl || kept_left[i] > nr ||
					kept_bottom[i] < nt || kept_top[i] > nb)
				continue;
			beat.hit  = 1'b1;
			beat.idx  = IDX_W'(i);
			beat.x0   = COVER_W'(((kept_left[i] > nl) ? kept_left[i] : nl) - kept_left[i]);
			beat.y0   = COVER_W'(((kept_top[i] > nt) ? kept_top[i] : nt) - kept_top[i]);
			beat.x1   = COVER_W'(((kept_right[i] < nr) ? kept_right[i] : nr) - kept_left[i]);
			beat.y1   = COVER_W'(((kept_bottom[i] < nb) ? kept_bottom[i] : nb) - kept_top[i]);
			beat.last = 1'b0;
			beat.ovf  = full;
			batch.push_back(beat);
		end
		if (batch.size() == 0) begin
			beat = '{hit: 1'b0, idx: '0, x0: '0, y0: '0, x1: '0, y1: '0,
				last: 1'b1, ovf: full};
			batch.push_back(beat);
		end else begin
			batch[batch.size()-1].last = 1'b1;
		end
		foreach (batch[k])
			expected_covers.push_back(batch[k]);
		if (!full) begin
			kept_left[kept_count]   = nl;
			kept_top[kept_count]    = nt;
			kept_right[kept_count]  = nr;
			kept_bottom[kept_count] = nb;
			kept_count++;
		end
	endfunction

	// called at a rising edge; returns at the edge where the beat is taken
	task automatic send_rect(input logic s, input logic [15:0] x, input logic [15:0] y,
			input logic [14:0] w, input logic [14:0] h);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		start_list <= s;
		rect_x     <= x;
		rect_y     <= y;
		rect_w     <= w;
		rect_h     <= h;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		predict_covers(s, x, y, w, h);
		items_sent++;
	endtask

	// mostly rectangles near a list center so they overlap, sometimes anywhere
	task automatic send_random(input logic s, input logic [15:0] cx, input logic [15:0] cy);
		logic [15:0] x, y;
		logic [14:0] w, h;
		if ($urandom_range(0, 5) == 0) begin
			x = 16'($urandom);
			y = 16'($urandom);
			w = 15'($urandom);
			h = 15'($urandom);
		end else begin
			x = 16'(cx + $urandom_range(0, 400) - 200);
			y = 16'(cy + $urandom_range(0, 400) - 200);
			w = 15'($urandom_range(0, 150));
			h = 15'($urandom_range(0, 150));
		end
		send_rect(s, x, y, w, h);
	endtask

	// drop valid so the last beat is not taken twice, then wait for every result
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_covers.size() != 0);
	endtask

	task automatic test_empty_store();
		send_rect(1'b0, 16'd20, 16'd20, 15'd5, 15'd5);
		send_rect(1'b1, 16'd20, 16'd20, 15'd5, 15'd5);
	endtask

	task automatic test_touching_edges();
		send_rect(1'b1, 16'd0, 16'd0, 15'd10, 15'd10);
		// corner to corner
		send_rect(1'b0, 16'd10, 16'd10, 15'd5, 15'd5);
		// one pixel right of the first, clear of both
		send_rect(1'b0, 16'd11, 16'd0, 15'd3, 15'd3);
		send_rect(1'b0, -16'sd5, -16'sd5, 15'd5, 15'd5);
		// zero size point inside the first
		send_rect(1'b0, 16'd3, 16'd3, 15'd0, 15'd0);
		send_rect(1'b0, 16'd100, 16'd100, 15'd1, 15'd1);
	endtask

	task automatic test_extreme_coords();
		send_rect(1'b1, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff);
		send_rect(1'b0, 16'hffff, 16'hffff, 15'd0, 15'd0);
		send_rect(1'b0, 16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff);
		send_rect(1'b0, 16'h8000, 16'h7fff, 15'h7fff, 15'd0);
		send_rect(1'b0, 16'h7fff, 16'h8000, 15'd0, 15'h7fff);
		send_rect(1'b0, 16'h8000, 16'h8000, 15'h7fff, 15'h7fff);
	endtask

	// every rectangle overlaps all earlier ones, so the store fills and results hit the cap
	task automatic test_full_store();
		for (int k = 0; k < NUM_RECTS + 3; k++)
			send_rect(k == 0, 16'(200 + k % 3), 16'(300 + k % 5), 15'(4 + k % 2), 15'd6);
		wait_drained();
	endtask

	task automatic run_lists(input int stop_at);
		logic [15:0] cx, cy;
		int          len;
		while (items_sent < stop_at) begin
			cx  = 16'($urandom);
			cy  = 16'($urandom);
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 40)
				: $urandom_range(1, 16);
			for (int k = 0; k < len; k++) begin
				// now and then a list carries on without a start, or restarts midway
				send_random((k == 0 && $urandom_range(0, 9) != 0) ||
					$urandom_range(0, 24) == 0, cx, cy);
				if ($urandom_range(0, 30) == 0)
					wait_drained();
			end
		end
	endtask

	task automatic test_random_lists();
		run_lists(RANDOM_END);
	endtask

	task automatic test_back_to_back();
		idle_en = 1'b0;
		run_lists(FINAL_END);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_touching_edges();
		test_extreme_coords();
		test_full_store();
		test_random_lists();
		test_back_to_back();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left--;
		else if (idle_en && $urandom_range(0, 4) == 0)
			stall_left = $urandom_range(1, 18);
		out_ready <= (stall_left == 0);
	end

	function automatic void check_field(input string name, input logic [14:0] want,
			input logic [14:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		cover_beat_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_covers.size() == 0) begin
				$error("result beat with nothing expected: hit %0b index %0d", hit, older_index);
				errors++;
			end else begin
				want = expected_covers.pop_front();
				check_field("hit", COVER_W'(want.hit), COVER_W'(hit));
				check_field("older_index", COVER_W'(want.idx), COVER_W'(older_index));
				check_field("cover_x0", want.x0, cover_x0);
				check_field("cover_y0", want.y0, cover_y0);
				check_field("cover_x1", want.x1, cover_x1);
				check_field("cover_y1", want.y1, cover_y1);
				check_field("last", COVER_W'(want.last), COVER_W'(last));
				check_field("overflow", COVER_W'(want.ovf), COVER_W'(overflow));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

FILE: filelist.f
rtl/rof_pkg.sv
rtl/rof_cell.sv
rtl/rof_cmp.sv
rtl/rectangle_occlusion_finder.sv
tb/tb_rectangle_occlusion_finder.sv
